// File: sv/brlpq_pkg.sv
// ----------------------------------------------------------------------------
// brlpq_pkg
// shared types and constants for the button repeat / long press qualifier
// ----------------------------------------------------------------------------
`default_nettype none

package brlpq_pkg;

	localparam int unsigned TIME_WIDTH_DEF = 32;

	localparam int unsigned CMD_W    = 2;
	localparam int unsigned BUTTON_W = 4;
	localparam int unsigned ACTION_W = 5;
	localparam int unsigned NOW_W    = 32;
	localparam int unsigned CFG_W    = 16;
	localparam int unsigned CFG_IDX_W = 2;

	// s_tdata packing: button, mapped_action, hold_timer, now_ms
	localparam int unsigned IN_FIELDS_W = BUTTON_W + ACTION_W + 1 + NOW_W;
	localparam int unsigned IN_DATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
	localparam int unsigned OUT_DATA_W  = ((ACTION_W + 7) / 8) * 8;

	typedef enum logic [CMD_W-1:0] {
		CMD_PRESS   = 2'd0,
		CMD_REPEAT  = 2'd1,
		CMD_RELEASE = 2'd2,
		CMD_TICK    = 2'd3
	} cmd_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_REPEAT_DELAY    = 2'd0,
		REG_REPEAT_INTERVAL = 2'd1,
		REG_LONG_PRESS      = 2'd2,
		REG_CHORD_HOLD      = 2'd3
	} reg_idx_t;

	localparam logic [BUTTON_W-1:0] BTN_R2    = 4'd11;
	localparam logic [BUTTON_W-1:0] BTN_START = 4'd12;
	localparam logic [BUTTON_W-1:0] BTN_MENU  = 4'd14;

	localparam logic [ACTION_W-1:0] ACT_NONE      = 5'd0;
	localparam logic [ACTION_W-1:0] ACT_UP        = 5'd1;
	localparam logic [ACTION_W-1:0] ACT_RIGHT     = 5'd4;
	localparam logic [ACTION_W-1:0] ACT_FAVORITES = 5'd5;
	localparam logic [ACTION_W-1:0] ACT_MAX_MAPPED = 5'd29;
	localparam logic [ACTION_W-1:0] ACT_SHUFFLE   = 5'd30;
	localparam logic [ACTION_W-1:0] ACT_RESET_MAP = 5'd31;

	localparam logic [CFG_W-1:0] REPEAT_DELAY_RST    = 16'd420;
	localparam logic [CFG_W-1:0] REPEAT_INTERVAL_RST = 16'd160;
	localparam logic [CFG_W-1:0] LONG_PRESS_RST      = 16'd800;
	localparam logic [CFG_W-1:0] CHORD_HOLD_RST      = 16'd3000;

	function automatic logic is_direction(input logic [ACTION_W-1:0] a);
		return (a >= ACT_UP) && (a <= ACT_RIGHT);
	endfunction

endpackage

`default_nettype wire

// File: sv/button_repeat_long_press_qualifier_unit.sv
// ----------------------------------------------------------------------------
// button_repeat_long_press_qualifier_unit
// qualifies button events: held-direction auto-repeat, os repeat rate limit,
// r2 favorites long press to shuffle, menu+start chord to reset mapping
// ----------------------------------------------------------------------------
// m_tvalid rises once an input transfer has passed the input register and then the result register
// throughput: one event per cycle unless stalled; all qualifying logic sits between the two registers
// s_tready drops only while the result register is full and m_tready is low
// reset (arst_n low): all hold/chord state cleared, registers at 420/160/800/3000
// config writes take effect at the next clock edge
// ----------------------------------------------------------------------------
`default_nettype none

module button_repeat_long_press_qualifier_unit
	import brlpq_pkg::*;
#(
	parameter int unsigned TIME_WIDTH = TIME_WIDTH_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_W-1:0]      cfg_data,
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	// [3:0] button, [8:4] action, [9] hold_timer, [41:10] now_ms
	input  wire logic [IN_DATA_W-1:0]  s_tdata,
	// [1:0] command
	input  wire logic [CMD_W-1:0]      s_tuser,
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	// [4:0] action_out
	output logic [OUT_DATA_W-1:0]      m_tdata
);

	typedef logic [TIME_WIDTH-1:0] tstamp_t;

	// config registers
	logic [CFG_W-1:0] repeat_delay_q, repeat_interval_q, long_press_q, chord_hold_q;

	// input stage
	logic                valid_s1;
	cmd_t                cmd_s1;
	logic [BUTTON_W-1:0] button_s1;
	logic [ACTION_W-1:0] action_s1;
	logic                hold_s1;
	logic [NOW_W-1:0]    now_s1;

	// result stage
	logic                valid_s2;
	logic [ACTION_W-1:0] action_s2;

	// qualifier state
	logic [ACTION_W-1:0] held_action_q, deferred_action_q;
	tstamp_t             held_since_q, last_repeat_q, long_pressed_at_q, chord_started_at_q;
	logic                long_pending_q, shuffle_emitted_q;
	logic                menu_down_q, start_down_q, chord_active_q, chord_emitted_q;

	// next-state
	logic [ACTION_W-1:0] held_action_d, deferred_action_d, result_d;
	tstamp_t             held_since_d, last_repeat_d, long_pressed_at_d, chord_started_at_d;
	logic                long_pending_d, shuffle_emitted_d;
	logic                menu_down_d, start_down_d, chord_active_d, chord_emitted_d;

	logic                advance;
	logic [ACTION_W-1:0] action;
	tstamp_t             now_t;
	logic                ge_interval, ge_delay, ge_long, ge_chord, ge_os_interval;

	function automatic tstamp_t elapsed(input tstamp_t now, input tstamp_t since);
		return now - since;
	endfunction

	assign advance  = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || advance;
	assign m_tvalid = valid_s2;
	assign m_tdata  = OUT_DATA_W'(action_s2);

	assign action = (action_s1 > ACT_MAX_MAPPED) ? ACT_NONE : action_s1;
	assign now_t  = TIME_WIDTH'(now_s1);

	assign ge_os_interval = elapsed(now_t, last_repeat_q) >= TIME_WIDTH'(repeat_interval_q);
	assign ge_interval    = ge_os_interval;
	assign ge_delay = elapsed(now_t, held_since_q) >= TIME_WIDTH'(repeat_delay_q);
	assign ge_long  = elapsed(now_t, long_pressed_at_q) >= TIME_WIDTH'(long_press_q);
	assign ge_chord = elapsed(now_t, chord_started_at_q) >= TIME_WIDTH'(chord_hold_q);

	always_comb begin
		held_action_d      = held_action_q;
		held_since_d       = held_since_q;
		last_repeat_d      = last_repeat_q;
		long_pending_d     = long_pending_q;
		shuffle_emitted_d  = shuffle_emitted_q;
		long_pressed_at_d  = long_pressed_at_q;
		deferred_action_d  = deferred_action_q;
		menu_down_d        = menu_down_q;
		start_down_d       = start_down_q;
		chord_active_d     = chord_active_q;
		chord_emitted_d    = chord_emitted_q;
		chord_started_at_d = chord_started_at_q;
		result_d           = ACT_NONE;

		// menu/start tracking on press and release
		if (cmd_s1 == CMD_PRESS || cmd_s1 == CMD_RELEASE) begin
			if (button_s1 == BTN_MENU)
				menu_down_d = (cmd_s1 == CMD_PRESS);
			if (button_s1 == BTN_START)
				start_down_d = (cmd_s1 == CMD_PRESS);
			if (menu_down_d && start_down_d) begin
				if (!chord_active_q) begin
					chord_active_d     = 1'b1;
					chord_emitted_d    = 1'b0;
					chord_started_at_d = now_t;
				end
			end else begin
				chord_active_d  = 1'b0;
				chord_emitted_d = 1'b0;
			end
		end

		case (cmd_s1)
			CMD_PRESS: begin
				if (!hold_s1)
					last_repeat_d = now_t;
				if (hold_s1 && is_direction(action)) begin
					held_action_d = action;
					held_since_d  = now_t;
					last_repeat_d = now_t;
				end
				// favorites on r2 is held back until release or long hold
				if (button_s1 == BTN_R2 && action == ACT_FAVORITES) begin
					long_pending_d    = 1'b1;
					shuffle_emitted_d = 1'b0;
					long_pressed_at_d = now_t;
					deferred_action_d = action;
				end else begin
					result_d = action;
				end
			end
			CMD_REPEAT: begin
				if (is_direction(action) && ge_os_interval) begin
					last_repeat_d = now_t;
					result_d      = action;
				end
			end
			CMD_RELEASE: begin
				if (action == held_action_q)
					held_action_d = ACT_NONE;
				if (button_s1 == BTN_R2 && long_pending_q) begin
					result_d          = shuffle_emitted_q ? ACT_NONE : deferred_action_q;
					long_pending_d    = 1'b0;
					shuffle_emitted_d = 1'b0;
					deferred_action_d = ACT_NONE;
				end
			end
			CMD_TICK: begin
				if (chord_active_q && !chord_emitted_q && ge_chord) begin
					chord_emitted_d = 1'b1;
					held_action_d   = ACT_NONE;
					result_d        = ACT_RESET_MAP;
				end else if (long_pending_q && !shuffle_emitted_q && ge_long) begin
					shuffle_emitted_d = 1'b1;
					result_d          = ACT_SHUFFLE;
				end else if (is_direction(held_action_q) && ge_delay && ge_interval) begin
					last_repeat_d = now_t;
					result_d      = held_action_q;
				end
			end
			default: begin
				result_d = ACT_NONE;
			end
		endcase
	end

	// config port
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			repeat_delay_q    <= REPEAT_DELAY_RST;
			repeat_interval_q <= REPEAT_INTERVAL_RST;
			long_press_q      <= LONG_PRESS_RST;
			chord_hold_q      <= CHORD_HOLD_RST;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_REPEAT_DELAY:    repeat_delay_q    <= cfg_data;
				REG_REPEAT_INTERVAL: repeat_interval_q <= cfg_data;
				REG_LONG_PRESS:      long_press_q      <= cfg_data;
				REG_CHORD_HOLD:      chord_hold_q      <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s_tready)
				valid_s1 <= s_tvalid;
			if (advance)
				valid_s2 <= 1'b1;
			else if (m_tready)
				valid_s2 <= 1'b0;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			cmd_s1    <= cmd_t'(s_tuser);
			button_s1 <= s_tdata[BUTTON_W-1:0];
			action_s1 <= s_tdata[BUTTON_W +: ACTION_W];
			hold_s1   <= s_tdata[BUTTON_W + ACTION_W];
			now_s1    <= s_tdata[BUTTON_W + ACTION_W + 1 +: NOW_W];
		end
		if (advance)
			action_s2 <= result_d;
	end

	// qualifier state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_action_q      <= ACT_NONE;
			held_since_q       <= '0;
			last_repeat_q      <= '0;
			long_pending_q     <= 1'b0;
			shuffle_emitted_q  <= 1'b0;
			long_pressed_at_q  <= '0;
			deferred_action_q  <= ACT_NONE;
			menu_down_q        <= 1'b0;
			start_down_q       <= 1'b0;
			chord_active_q     <= 1'b0;
			chord_emitted_q    <= 1'b0;
			chord_started_at_q <= '0;
		end else if (advance) begin
			held_action_q      <= held_action_d;
			held_since_q       <= held_since_d;
			last_repeat_q      <= last_repeat_d;
			long_pending_q     <= long_pending_d;
			shuffle_emitted_q  <= shuffle_emitted_d;
			long_pressed_at_q  <= long_pressed_at_d;
			deferred_action_q  <= deferred_action_d;
			menu_down_q        <= menu_down_d;
			start_down_q       <= start_down_d;
			chord_active_q     <= chord_active_d;
			chord_emitted_q    <= chord_emitted_d;
			chord_started_at_q <= chord_started_at_d;
		end
	end

	// held action is always none or a direction
	a_held_is_direction: assert property (@(posedge clk) disable iff (!arst_n)
		held_action_q == ACT_NONE || is_direction(held_action_q))
		else $error("held action not a direction");

	a_shuffle_needs_pending: assert property (@(posedge clk) disable iff (!arst_n)
		shuffle_emitted_q |-> long_pending_q)
		else $error("shuffle emitted without pending long press");

	a_pending_holds_fav: assert property (@(posedge clk) disable iff (!arst_n)
		long_pending_q |-> deferred_action_q == ACT_FAVORITES)
		else $error("pending long press without deferred favorites");

	a_chord_tracks_buttons: assert property (@(posedge clk) disable iff (!arst_n)
		chord_active_q == (menu_down_q && start_down_q))
		else $error("chord state out of step with menu/start");

	a_chord_emit_active: assert property (@(posedge clk) disable iff (!arst_n)
		chord_emitted_q |-> chord_active_q)
		else $error("chord emitted while inactive");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> s_tready)
		else $error("input stalled with empty input stage");

endmodule

`default_nettype wire
